>>> hdl/ptc_pkg.sv
// Shared constants, the calibration coefficient bundle and shift helpers
// for the pressure and temperature compensation pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ptc_pkg;

	localparam int CFG_W     = 64;
	localparam int IDX_W     = 2;
	localparam int ADC_W     = 20;
	localparam int TOUT_W    = 16;
	localparam int PRESS_W   = 25;
	localparam int DIV_STEPS = 64;

	localparam logic [IDX_W-1:0] REG_TEMP   = 2'd0;
	localparam logic [IDX_W-1:0] REG_P_LOW  = 2'd1;
	localparam logic [IDX_W-1:0] REG_P_HIGH = 2'd2;
	localparam logic [IDX_W-1:0] REG_P_LAST = 2'd3;

	localparam logic [63:0] FINE_OFFSET = 64'd128000;
	localparam logic [63:0] ADC_FULL    = 64'd1048576;
	localparam logic [63:0] PRESS_SCALE = 64'd3125;
	localparam logic [31:0] TEMP_ROUND  = 32'd128;
	localparam logic [63:0] W1_BIAS     = 64'h0000_8000_0000_0000;
	localparam logic [PRESS_W-1:0] PRESS_MAX = {PRESS_W{1'b1}};

	// Calibration words; all fields are raw 16-bit slices, sign handled at use.
	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic [15:0] p4;
		logic [15:0] p5;
		logic [15:0] p6;
		logic [15:0] p7;
		logic [15:0] p8;
		logic [15:0] p9;
	} coef_t;

	function automatic logic [63:0] sx64(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	function automatic logic [31:0] sx32(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [63:0] sra64(input logic [63:0] x, input int unsigned n);
		logic signed [63:0] s;
		s = x;
		return s >>> n;
	endfunction

	function automatic logic [31:0] sra32(input logic [31:0] x, input int unsigned n);
		logic signed [31:0] s;
		s = x;
		return s >>> n;
	endfunction

endpackage

`default_nettype wire

>>> hdl/ptc_mul64.sv
// Two-stage multiplier giving the low 64 bits of a 64 by 64 product,
// built from three 32 by 32 partial products. Uses no package.
`timescale 1ns / 1ps
`default_nettype none

module ptc_mul64 (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic      [63:0] p
);

	logic [63:0] ll;
	logic [31:0] lh;
	logic [31:0] hl;
	logic [63:0] ll_s1;
	logic [31:0] lh_s1;
	logic [31:0] hl_s1;
	logic [63:0] p_s2;

	assign ll = {32'b0, a[31:0]} * {32'b0, b[31:0]};
	assign lh = a[31:0] * b[63:32];
	assign hl = a[63:32] * b[31:0];

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= ll;
			lh_s1 <= lh;
			hl_s1 <= hl;
			p_s2  <= ll_s1 + {lh_s1 + hl_s1, 32'b0};
		end
	end

	assign p = p_s2;

endmodule

`default_nettype wire

>>> hdl/ptc_temp.sv
// Temperature section: unpacks both ADC words and computes the fine
// temperature, the saturated centi-degree result and the first pressure term.
// Depends on ptc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptc_temp import ptc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_vld,
	input  wire coef_t             coef,
	input  wire logic [7:0]        temp_msb,
	input  wire logic [7:0]        temp_lsb,
	input  wire logic [7:0]        temp_xlsb,
	input  wire logic [7:0]        press_msb,
	input  wire logic [7:0]        press_lsb,
	input  wire logic [7:0]        press_xlsb,
	output logic                   out_vld,
	output logic [TOUT_W-1:0]      tout,
	output logic [63:0]            w1,
	output logic [ADC_W-1:0]       adc_p
);

	logic [ADC_W-1:0] adc_t;
	logic [31:0] a_in, d_in, v1, x3, v2, f5, tc;
	logic signed [31:0] tc_s;
	logic [TOUT_W-1:0] tsat;

	logic [31:0] a_s1, d_s1, m1_s2, dd_s2, v1_s3, m3_s3, fine_s4;
	logic [ADC_W-1:0] adcp_s1, adcp_s2, adcp_s3, adcp_s4, adcp_s5;
	logic [TOUT_W-1:0] tout_s5;
	logic [63:0] w1_s5;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	assign adc_t = {temp_msb, temp_lsb, temp_xlsb[7:4]};
	assign a_in  = 32'(adc_t[19:3]) - {15'b0, coef.t1, 1'b0};
	assign d_in  = 32'(adc_t[19:4]) - 32'(coef.t1);

	assign v1 = sra32(m1_s2, 11);
	assign x3 = sra32(dd_s2, 12);
	assign v2 = sra32(m3_s3, 14);
	assign f5 = fine_s4 + {fine_s4[29:0], 2'b0} + TEMP_ROUND;
	assign tc = sra32(f5, 8);
	assign tc_s = tc;

	always_comb begin
		if (tc_s < -32'sd32768) begin
			tsat = 16'h8000;
		end else if (tc_s > 32'sd32767) begin
			tsat = 16'h7FFF;
		end else begin
			tsat = tc[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= a_in;
			d_s1    <= d_in;
			adcp_s1 <= {press_msb, press_lsb, press_xlsb[7:4]};
			m1_s2   <= a_s1 * sx32(coef.t2);
			dd_s2   <= d_s1 * d_s1;
			adcp_s2 <= adcp_s1;
			v1_s3   <= v1;
			m3_s3   <= x3 * sx32(coef.t3);
			adcp_s3 <= adcp_s2;
			fine_s4 <= v1_s3 + v2;
			adcp_s4 <= adcp_s3;
			tout_s5 <= tsat;
			w1_s5   <= {{32{fine_s4[31]}}, fine_s4} - FINE_OFFSET;
			adcp_s5 <= adcp_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	assign out_vld = vld_s5;
	assign tout    = tout_s5;
	assign w1      = w1_s5;
	assign adc_p   = adcp_s5;

endmodule

`default_nettype wire

>>> hdl/ptc_press_pre.sv
// Pressure section ahead of the division: builds the dividend and divisor
// with 64-bit wrapping arithmetic. Depends on ptc_pkg and ptc_mul64.
`timescale 1ns / 1ps
`default_nettype none

module ptc_press_pre import ptc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_vld,
	input  wire coef_t             coef,
	input  wire logic [63:0]       w1,
	input  wire logic [ADC_W-1:0]  adc_p,
	input  wire logic [TOUT_W-1:0] tout_in,
	output logic                   out_vld,
	output logic [63:0]            num,
	output logic [63:0]            den,
	output logic [TOUT_W-1:0]      tout_out
);

	logic [63:0] sq, m5, m2, q6, q3, numf, denf;
	logic [63:0] m5_s3, m5_s4, m2_s3, m2_s4;
	logic [ADC_W-1:0] adcp_s1, adcp_s2, adcp_s3, adcp_s4;
	logic [63:0] w2_s5, t_s5, pp_s5, nd_s6, t_s6, num_s9, den_s9;
	logic [TOUT_W-1:0] tout_s1, tout_s2, tout_s3, tout_s4, tout_s5, tout_s6;
	logic [TOUT_W-1:0] tout_s7, tout_s8, tout_s9;
	logic [8:0] vld_q;

	ptc_mul64 u_sq (.clk(clk), .en(en), .a(w1), .b(w1), .p(sq));
	ptc_mul64 u_m5 (.clk(clk), .en(en), .a(w1), .b(sx64(coef.p5)), .p(m5));
	ptc_mul64 u_m2 (.clk(clk), .en(en), .a(w1), .b(sx64(coef.p2)), .p(m2));
	ptc_mul64 u_q6 (.clk(clk), .en(en), .a(sq), .b(sx64(coef.p6)), .p(q6));
	ptc_mul64 u_q3 (.clk(clk), .en(en), .a(sq), .b(sx64(coef.p3)), .p(q3));
	ptc_mul64 u_nm (.clk(clk), .en(en), .a(nd_s6), .b(PRESS_SCALE), .p(numf));
	ptc_mul64 u_dn (.clk(clk), .en(en), .a(t_s6), .b({48'b0, coef.p1}), .p(denf));

	always_ff @(posedge clk) begin
		if (en) begin
			adcp_s1 <= adc_p;
			adcp_s2 <= adcp_s1;
			adcp_s3 <= adcp_s2;
			adcp_s4 <= adcp_s3;
			tout_s1 <= tout_in;
			tout_s2 <= tout_s1;
			tout_s3 <= tout_s2;
			tout_s4 <= tout_s3;
			tout_s5 <= tout_s4;
			tout_s6 <= tout_s5;
			tout_s7 <= tout_s6;
			tout_s8 <= tout_s7;
			tout_s9 <= tout_s8;
			// Products m5 and m2 leave their multipliers at stage 2.
			m5_s3   <= m5;
			m2_s3   <= m2;
			m5_s4   <= m5_s3;
			m2_s4   <= m2_s3;
			w2_s5   <= q6 + {m5_s4[46:0], 17'b0} + {{13{coef.p4[15]}}, coef.p4, 35'b0};
			t_s5    <= W1_BIAS + sra64(q3, 8) + {m2_s4[51:0], 12'b0};
			pp_s5   <= ADC_FULL - 64'(adcp_s4);
			nd_s6   <= {pp_s5[32:0], 31'b0} - w2_s5;
			t_s6    <= t_s5;
			num_s9  <= numf;
			den_s9  <= sra64(denf, 33);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[7:0], in_vld};
		end
	end

	assign out_vld  = vld_q[8];
	assign num      = num_s9;
	assign den      = den_s9;
	assign tout_out = tout_s9;

endmodule

`default_nettype wire

>>> hdl/ptc_div.sv
// Pipelined signed 64-bit divider, one restoring quotient bit per stage,
// truncating toward zero, with a side payload carried along. Depends on ptc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptc_div import ptc_pkg::*; #(
	parameter int SIDE_W = TOUT_W
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_vld,
	input  wire logic [63:0]       num,
	input  wire logic [63:0]       den,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic                   out_vld,
	output logic [63:0]            quo,
	output logic                   zero,
	output logic [SIDE_W-1:0]      side_out
);

	logic [63:0]       rem_s  [0:DIV_STEPS];
	logic [63:0]       acc_s  [0:DIV_STEPS];
	logic [63:0]       mb_s   [0:DIV_STEPS];
	logic              neg_s  [0:DIV_STEPS];
	logic              zero_s [0:DIV_STEPS];
	logic [SIDE_W-1:0] side_s [0:DIV_STEPS];
	logic              vld_s  [0:DIV_STEPS];

	logic [63:0]       quo_q;
	logic              zero_q;
	logic [SIDE_W-1:0] side_q;
	logic              vld_q;

	// Operands enter as magnitudes; the sign is restored at the end.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= 64'b0;
			acc_s[0]  <= num[63] ? (64'b0 - num) : num;
			mb_s[0]   <= den[63] ? (64'b0 - den) : den;
			neg_s[0]  <= num[63] ^ den[63];
			zero_s[0] <= (den == 64'b0);
			side_s[0] <= side_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	genvar k;
	generate
		for (k = 0; k < DIV_STEPS; k++) begin : g_step
			logic [64:0] trial;
			logic [64:0] diff;
			logic        ge;

			assign trial = {rem_s[k], acc_s[k][63]};
			assign diff  = trial - {1'b0, mb_s[k]};
			assign ge    = !diff[64];

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1]  <= ge ? diff[63:0] : trial[63:0];
					acc_s[k+1]  <= {acc_s[k][62:0], ge};
					mb_s[k+1]   <= mb_s[k];
					neg_s[k+1]  <= neg_s[k];
					zero_s[k+1] <= zero_s[k];
					side_s[k+1] <= side_s[k];
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k+1] <= 1'b0;
				end else if (en) begin
					vld_s[k+1] <= vld_s[k];
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			quo_q  <= neg_s[DIV_STEPS] ? (64'b0 - acc_s[DIV_STEPS]) : acc_s[DIV_STEPS];
			zero_q <= zero_s[DIV_STEPS];
			side_q <= side_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_s[DIV_STEPS];
		end
	end

	assign out_vld  = vld_q;
	assign quo      = quo_q;
	assign zero     = zero_q;
	assign side_out = side_q;

endmodule

`default_nettype wire

>>> hdl/ptc_press_post.sv
// Pressure section after the division: second-order correction, offset,
// saturation and the output register. Depends on ptc_pkg and ptc_mul64.
`timescale 1ns / 1ps
`default_nettype none

module ptc_press_post import ptc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_vld,
	input  wire coef_t             coef,
	input  wire logic [63:0]       p,
	input  wire logic              zero,
	input  wire logic [TOUT_W-1:0] tout_in,
	output logic                   out_vld,
	output logic [TOUT_W-1:0]      temperature_centi,
	output logic [PRESS_W-1:0]     pressure_q8,
	output logic                   pressure_valid
);

	logic [63:0] ps, sq2, x1f, x2f, r;
	logic [PRESS_W-1:0] psat;
	logic [63:0] p_s1, p_s2, p_s3, p_s4, x2f_s3, x2f_s4, sum_s5;
	logic zero_s1, zero_s2, zero_s3, zero_s4, zero_s5;
	logic [TOUT_W-1:0] tout_s1, tout_s2, tout_s3, tout_s4, tout_s5, tout_s6;
	logic [PRESS_W-1:0] pres_s6;
	logic pval_s6;
	logic [5:0] vld_q;

	assign ps = sra64(p, 13);

	ptc_mul64 u_ps (.clk(clk), .en(en), .a(ps), .b(ps), .p(sq2));
	ptc_mul64 u_x2 (.clk(clk), .en(en), .a(p), .b(sx64(coef.p8)), .p(x2f));
	ptc_mul64 u_x1 (.clk(clk), .en(en), .a(sq2), .b(sx64(coef.p9)), .p(x1f));

	assign r = sra64(sum_s5, 8) + {{44{coef.p7[15]}}, coef.p7, 4'b0};

	always_comb begin
		if (r[63]) begin
			psat = '0;
		end else if (|r[62:PRESS_W]) begin
			psat = PRESS_MAX;
		end else begin
			psat = r[PRESS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= p;
			p_s2    <= p_s1;
			p_s3    <= p_s2;
			p_s4    <= p_s3;
			zero_s1 <= zero;
			zero_s2 <= zero_s1;
			zero_s3 <= zero_s2;
			zero_s4 <= zero_s3;
			zero_s5 <= zero_s4;
			tout_s1 <= tout_in;
			tout_s2 <= tout_s1;
			tout_s3 <= tout_s2;
			tout_s4 <= tout_s3;
			tout_s5 <= tout_s4;
			tout_s6 <= tout_s5;
			x2f_s3  <= x2f;
			x2f_s4  <= x2f_s3;
			sum_s5  <= p_s4 + sra64(x1f, 25) + sra64(x2f_s4, 19);
			pres_s6 <= zero_s5 ? '0 : psat;
			pval_s6 <= !zero_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[4:0], in_vld};
		end
	end

	assign out_vld           = vld_q[5];
	assign temperature_centi = tout_s6;
	assign pressure_q8       = pres_s6;
	assign pressure_valid    = pval_s6;

endmodule

`default_nettype wire

>>> hdl/pressure_temperature_compensation.sv
// Top level of the barometric compensation pipeline: configuration registers
// and the chain temperature, pressure pre-division, divider, post-correction.
// Depends on ptc_pkg, ptc_temp, ptc_press_pre, ptc_div and ptc_press_post.
//
// Use: each input beat on in_valid/in_ready carries six raw sensor bytes and
// yields exactly one output beat on out_valid/out_ready holding the saturated
// temperature in hundredths of a degree, pressure in Pa as Q17.8 and a flag
// that is low when the divisor term came out zero (pressure then reads 0).
// Calibration lives in four registers written on the cfg_valid/cfg_ready
// channel by index; cfg_ready is always high. Write them only while no beat
// is in flight.
// An accepted input beat passes five temperature stages, nine stages of 64-bit
// products built from two-stage partial-product multipliers, 66 divider stages
// (one quotient bit per stage plus sign handling) and six correction stages.
// One beat is accepted every cycle while no finished result is stalled.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes and in_ready drops; nothing is lost or repeated.
// Reset clears all valid bits and sets every calibration register to zero.
`timescale 1ns / 1ps
`default_nettype none

module pressure_temperature_compensation import ptc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         temp_msb,
	input  wire logic [7:0]         temp_lsb,
	input  wire logic [7:0]         temp_xlsb,
	input  wire logic [7:0]         press_msb,
	input  wire logic [7:0]         press_lsb,
	input  wire logic [7:0]         press_xlsb,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [TOUT_W-1:0] temperature_centi,
	output logic [PRESS_W-1:0]      pressure_q8,
	output logic                    pressure_valid
);

	logic [47:0] temp_coeffs_q;
	logic [63:0] press_low_q;
	logic [63:0] press_high_q;
	logic [15:0] press_last_q;
	coef_t coef;

	// Global advance: every stage moves unless a finished result is stalled.
	logic adv;

	logic               t_vld;
	logic [TOUT_W-1:0]  t_tout;
	logic [63:0]        t_w1;
	logic [ADC_W-1:0]   t_adcp;

	logic               pre_vld;
	logic [63:0]        pre_num;
	logic [63:0]        pre_den;
	logic [TOUT_W-1:0]  pre_tout;

	logic               div_vld;
	logic [63:0]        div_quo;
	logic               div_zero;
	logic [TOUT_W-1:0]  div_tout;

	logic [TOUT_W-1:0]  post_tout;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coeffs_q <= '0;
			press_low_q   <= '0;
			press_high_q  <= '0;
			press_last_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TEMP:   temp_coeffs_q <= cfg_data[47:0];
				REG_P_LOW:  press_low_q   <= cfg_data;
				REG_P_HIGH: press_high_q  <= cfg_data;
				REG_P_LAST: press_last_q  <= cfg_data[15:0];
				default:    ;
			endcase
		end
	end

	assign coef.t1 = temp_coeffs_q[15:0];
	assign coef.t2 = temp_coeffs_q[31:16];
	assign coef.t3 = temp_coeffs_q[47:32];
	assign coef.p1 = press_low_q[15:0];
	assign coef.p2 = press_low_q[31:16];
	assign coef.p3 = press_low_q[47:32];
	assign coef.p4 = press_low_q[63:48];
	assign coef.p5 = press_high_q[15:0];
	assign coef.p6 = press_high_q[31:16];
	assign coef.p7 = press_high_q[47:32];
	assign coef.p8 = press_high_q[63:48];
	assign coef.p9 = press_last_q;

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	ptc_temp u_temp (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_vld(in_valid), .coef(coef),
		.temp_msb(temp_msb), .temp_lsb(temp_lsb), .temp_xlsb(temp_xlsb),
		.press_msb(press_msb), .press_lsb(press_lsb), .press_xlsb(press_xlsb),
		.out_vld(t_vld), .tout(t_tout), .w1(t_w1), .adc_p(t_adcp)
	);

	ptc_press_pre u_pre (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_vld(t_vld), .coef(coef),
		.w1(t_w1), .adc_p(t_adcp), .tout_in(t_tout),
		.out_vld(pre_vld), .num(pre_num), .den(pre_den), .tout_out(pre_tout)
	);

	ptc_div #(.SIDE_W(TOUT_W)) u_div (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_vld(pre_vld),
		.num(pre_num), .den(pre_den), .side_in(pre_tout),
		.out_vld(div_vld), .quo(div_quo), .zero(div_zero), .side_out(div_tout)
	);

	ptc_press_post u_post (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_vld(div_vld), .coef(coef),
		.p(div_quo), .zero(div_zero), .tout_in(div_tout),
		.out_vld(out_valid), .temperature_centi(post_tout),
		.pressure_q8(pressure_q8), .pressure_valid(pressure_valid)
	);

	assign temperature_centi = post_tout;

endmodule

`default_nettype wire
